// ===== rtl/core/tws_pkg.sv =====
// tws_pkg: constants, register codes and tanh table point generation
// for the tanh saturation waveshaper; no dependencies
package tws_pkg;

	typedef enum logic {
		REG_DRIVE = 1'b0,
		REG_CHAR  = 1'b1
	} reg_idx_t;

	localparam int LEVEL_BITS = 11;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 11'd1024;
	localparam logic [15:0] K065 = 16'd42598;
	localparam logic [15:0] K008 = 16'd5243;
	localparam logic [15:0] COL_BASE = 16'd6554;
	localparam logic [15:0] COL_SPAN = 16'd26214;
	localparam longint Q30 = longint'(1) << 30;

	// unsigned long division by shift and subtract, non-negative operands
	function automatic longint udiv(longint n, longint d);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] nn;
		logic [63:0] dd;
		q = '0;
		r = '0;
		nn = n;
		dd = d;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], nn[i]};
			if (r >= dd) begin
				r = r - dd;
				q[i] = 1'b1;
			end
		end
		return longint'(q);
	endfunction

	// e^(-t), t and result in q30, 0 <= t <= 1
	function automatic longint exp_neg_q30(longint t);
		longint term;
		longint sum;
		term = Q30;
		sum = Q30;
		for (int k = 1; k <= 20; k++) begin
			term = (term * t) >>> 30;
			term = udiv(term, longint'(k));
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	// tanh(x) for x with f fraction bits, 0 <= x <= 8
	function automatic longint tanh_point(longint x, int f);
		longint y;
		longint n;
		longint fr;
		longint e1;
		longint e;
		longint num;
		longint den;
		y = 2 * x;
		n = y >>> f;
		fr = y & ((longint'(1) << f) - 1);
		e1 = exp_neg_q30(Q30);
		e = exp_neg_q30(fr << (30 - f));
		for (longint i = 0; i < n; i++) begin
			e = (e * e1 + (Q30 >>> 1)) >>> 30;
		end
		if (e < 0) begin
			e = 0;
		end
		num = (Q30 - e) << f;
		den = Q30 + e;
		return udiv(num + (den >>> 1), den);
	endfunction

endpackage

// ===== rtl/core/tws_in_if.sv =====
// tws_in_if: input sample channel, valid/ready with one sample per word
// depends on nothing
interface tws_in_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/tws_out_if.sv =====
// tws_out_if: output sample channel, valid/ready with one sample per word
// depends on nothing
interface tws_out_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/tws_div.sv =====
// tws_div: pipelined restoring divider, one quotient bit per stage,
// elastic valid/ready chain with sideband; no dependencies
module tws_div #(
	parameter int DW = 50,
	parameter int NW = 21,
	parameter int QB = 25,
	parameter int SW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] in_d,
	input  logic [NW-1:0] in_norm,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [QB-1:0] out_q,
	output logic [SW-1:0] out_side
);

	logic          v_s    [QB];
	logic [DW-1:0] rem_s  [QB];
	logic [QB-1:0] q_s    [QB];
	logic [NW-1:0] nrm_s  [QB];
	logic [SW-1:0] side_s [QB];
	logic          en     [QB+1];

	assign en[QB] = out_ready;
	assign in_ready = en[0];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		logic          pv;
		logic [DW-1:0] prem;
		logic [QB-1:0] pq;
		logic [NW-1:0] pn;
		logic [SW-1:0] pside;
		logic [DW-1:0] sub;
		logic          take;

		if (j == 0) begin : g_first
			assign pv = in_valid;
			assign prem = in_d;
			assign pq = '0;
			assign pn = in_norm;
			assign pside = in_side;
		end else begin : g_next
			assign pv = v_s[j-1];
			assign prem = rem_s[j-1];
			assign pq = q_s[j-1];
			assign pn = nrm_s[j-1];
			assign pside = side_s[j-1];
		end

		assign en[j] = !v_s[j] || en[j+1];
		assign sub = DW'(pn) << (QB - 1 - j);
		assign take = prem >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en[j]) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= take ? prem - sub : prem;
				q_s[j] <= pq | (QB'(take) << (QB - 1 - j));
				nrm_s[j] <= pn;
				side_s[j] <= pside;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign out_q = q_s[QB-1];
	assign out_side = side_s[QB-1];

endmodule

// ===== rtl/core/tanh_saturation_waveshaper.sv =====
// tanh_saturation_waveshaper: top level, apb register port, front pipeline,
// output register; depends on tws_pkg, tws_in_if, tws_out_if, tws_div
//
// usage
//  in_ch carries one signed q3.f sample per word, out_ch one shaped sample
//  per word, valid/ready on both, accepted when valid and ready are high
//  drive and character are written over apb at byte addresses 0 and 4,
//  values with low 11 bits above 1024 are clamped to 1024; both zero
//  passes samples through
//  one word enters per cycle when out_ch keeps up; seven front stages
//  (gain, squares, table reads, interpolation, blend, dividend), one stage
//  per quotient bit of the normalizing divider, then the output register
//  every stage has its own valid bit, so bubbles close up under a stall;
//  a stalled out_ch holds its word and back-pressure reaches in_ch only
//  once every stage is full
//  reset clears the registers to zero and empties the pipeline; the tanh
//  table is a constant array built at elaboration
//  TANH_TABLE_ENTRIES must be a power of two; the block does not enforce it
module tanh_saturation_waveshaper #(
	parameter int SAMPLE_BITS = 24,
	parameter int TANH_TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tws_in_if.sink      in_ch,
	tws_out_if.source   out_ch
);
	import tws_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int F   = SB - 4;
	localparam int N   = TANH_TABLE_ENTRIES;
	localparam int SH  = SB - 1 - $clog2(N);
	localparam int IW  = $clog2(N + 1);
	localparam int AW  = SB + 3;
	localparam int TW  = F + 1;
	localparam int CW3 = F + 7;
	localparam int MW  = F + 8;
	localparam int QB  = SB + 1;
	localparam int CW  = 2 * F + 10;
	localparam int SW  = SB + 3;
	localparam logic [TW-1:0] THR = TW'((longint'(1) << F) / 1000);
	localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

	typedef logic [TW-1:0] tbl_t [N+1];

	typedef struct packed {
		logic [TW-1:0] lo;
		logic [TW-1:0] diff;
		logic [SH-1:0] fr;
	} lk_t;

	function automatic tbl_t build_tbl();
		tbl_t t;
		for (int i = 0; i <= N; i++) begin
			t[i] = TW'(tanh_point(longint'(i) << SH, F));
		end
		return t;
	endfunction

	localparam tbl_t TANH_TBL = build_tbl();

	function automatic lk_t lk_read(logic [AW-1:0] a);
		logic [AW-SH-1:0] idxf;
		logic             sat;
		logic [IW-1:0]    idx;
		logic [IW-1:0]    idx_hi;
		logic [TW-1:0]    lo;
		logic [TW-1:0]    hi;
		lk_t              r;
		idxf = a[AW-1:SH];
		sat = idxf >= (AW-SH)'(N);
		idx = sat ? IW'(N) : idxf[IW-1:0];
		idx_hi = sat ? IW'(N) : idx + IW'(1);
		lo = TANH_TBL[idx];
		hi = TANH_TBL[idx_hi];
		r.lo = lo;
		r.diff = (sat || hi < lo) ? '0 : hi - lo;
		r.fr = a[SH-1:0];
		return r;
	endfunction

	function automatic logic [TW-1:0] lk_interp(lk_t l);
		logic [TW+SH:0] p;
		p = (TW+SH+1)'(l.diff) * (TW+SH+1)'(l.fr) + (TW+SH+1)'(1 << (SH - 1));
		return l.lo + TW'(p >> SH);
	endfunction

	// configuration registers
	logic [LEVEL_BITS-1:0] drive_q;
	logic [LEVEL_BITS-1:0] char_q;
	logic [LEVEL_BITS-1:0] wlev;
	reg_idx_t              widx;

	assign pready = 1'b1;
	assign widx = reg_idx_t'(paddr[2]);
	assign wlev = (pwdata[LEVEL_BITS-1:0] > LEVEL_MAX) ? LEVEL_MAX : pwdata[LEVEL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
			char_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_DRIVE: drive_q <= wlev;
				REG_CHAR:  char_q <= wlev;
				default:   drive_q <= drive_q;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_DRIVE: prdata = 32'(drive_q);
			REG_CHAR:  prdata = 32'(char_q);
			default:   prdata = '0;
		endcase
	end

	// stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;
	logic div_in_ready, div_out_valid, div_out_ready;

	assign en7 = !v_s7 || div_in_ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// s1: magnitude, sign, gains
	logic [SB-1:0] raw_s1, m_s1;
	logic          neg_s1, byp_s1;
	logic [13:0]   amt_s1;
	logic [15:0]   col_s1;
	logic [25:0]   colp;

	assign colp = 26'(COL_SPAN) * 26'(char_q) + 26'd512;

	always_ff @(posedge clk) begin
		if (en1) begin
			raw_s1 <= in_ch.sample_in;
			neg_s1 <= in_ch.sample_in[SB-1];
			m_s1 <= in_ch.sample_in[SB-1] ? -in_ch.sample_in : in_ch.sample_in;
			byp_s1 <= (drive_q == '0) && (char_q == '0);
			amt_s1 <= 14'd1024 + 14'd7 * 14'(drive_q);
			col_s1 <= COL_BASE + 16'(colp >> 10);
		end
	end

	// s2: scaled argument, square
	logic [SB-1:0] raw_s2, m_s2;
	logic          neg_s2, byp_s2;
	logic [13:0]   amt_s2;
	logic [15:0]   col_s2;
	logic [AW-1:0] a1_s2, m2_s2;
	logic [SB+13:0]  p_a1;
	logic [2*SB-1:0] p_m2;

	assign p_a1 = (SB+14)'(m_s1) * (SB+14)'(amt_s1) + (SB+14)'(512);
	assign p_m2 = (2*SB)'(m_s1) * (2*SB)'(m_s1) + (2*SB)'(1 << (F - 1));

	always_ff @(posedge clk) begin
		if (en2) begin
			raw_s2 <= raw_s1;
			neg_s2 <= neg_s1;
			byp_s2 <= byp_s1;
			m_s2 <= m_s1;
			amt_s2 <= amt_s1;
			col_s2 <= col_s1;
			a1_s2 <= AW'(p_a1 >> 10);
			m2_s2 <= AW'(p_m2 >> F);
		end
	end

	// s3: 0.65 argument, 0.08 square, norm argument
	logic [SB-1:0] raw_s3, m_s3, k_s3;
	logic          neg_s3, byp_s3;
	logic [15:0]   col_s3;
	logic [AW-1:0] a1_s3, a2_s3, na_s3;
	logic [AW+15:0] p_a2, p_k;

	assign p_a2 = (AW+16)'(a1_s2) * (AW+16)'(K065) + (AW+16)'(32768);
	assign p_k = (AW+16)'(m2_s2) * (AW+16)'(K008) + (AW+16)'(32768);

	always_ff @(posedge clk) begin
		if (en3) begin
			raw_s3 <= raw_s2;
			neg_s3 <= neg_s2;
			byp_s3 <= byp_s2;
			m_s3 <= m_s2;
			col_s3 <= col_s2;
			a1_s3 <= a1_s2;
			a2_s3 <= AW'(p_a2 >> 16);
			k_s3 <= SB'(p_k >> 16);
			na_s3 <= AW'(amt_s2) << (F - 10);
		end
	end

	// s4: table reads, cube
	logic [SB-1:0]  raw_s4;
	logic           neg_s4, byp_s4;
	logic [15:0]    col_s4;
	lk_t            l1_s4, l2_s4, ln_s4;
	logic [CW3-1:0] cube_s4;
	logic [2*SB:0]  p_cube;

	assign p_cube = (2*SB+1)'(k_s3) * (2*SB+1)'(m_s3) + (2*SB+1)'(1 << (F - 1));

	always_ff @(posedge clk) begin
		if (en4) begin
			raw_s4 <= raw_s3;
			neg_s4 <= neg_s3;
			byp_s4 <= byp_s3;
			col_s4 <= col_s3;
			l1_s4 <= lk_read(a1_s3);
			l2_s4 <= lk_read(a2_s3);
			ln_s4 <= lk_read(na_s3);
			cube_s4 <= CW3'(p_cube >> F);
		end
	end

	// s5: interpolation
	logic [SB-1:0]  raw_s5;
	logic           neg_s5, byp_s5;
	logic [15:0]    col_s5;
	logic [TW-1:0]  t1_s5, t2_s5, nrm_s5;
	logic [CW3-1:0] cube_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			raw_s5 <= raw_s4;
			neg_s5 <= neg_s4;
			byp_s5 <= byp_s4;
			col_s5 <= col_s4;
			t1_s5 <= lk_interp(l1_s4);
			t2_s5 <= lk_interp(l2_s4);
			nrm_s5 <= lk_interp(ln_s4);
			cube_s5 <= cube_s4;
		end
	end

	// s6: blend, norm floor
	logic [SB-1:0] raw_s6;
	logic          neg_s6, byp_s6;
	logic [MW-1:0] mix_s6;
	logic [TW-1:0] nrm_s6;
	logic [F+24:0] p_mix;

	assign p_mix = (F+25)'(17'd65536 - 17'(col_s5)) * (F+25)'(t1_s5)
		+ (F+25)'(col_s5) * ((F+25)'(t2_s5) + (F+25)'(cube_s5)) + (F+25)'(32768);

	always_ff @(posedge clk) begin
		if (en6) begin
			raw_s6 <= raw_s5;
			neg_s6 <= neg_s5;
			byp_s6 <= byp_s5;
			mix_s6 <= MW'(p_mix >> 16);
			nrm_s6 <= (nrm_s5 < THR) ? THR : nrm_s5;
		end
	end

	// s7: dividend, overflow check
	logic [SB-1:0] raw_s7;
	logic          neg_s7, byp_s7, ovf_s7;
	logic [CW-1:0] d_s7;
	logic [TW-1:0] nrm_s7;
	logic [CW-1:0] dnext;

	assign dnext = (CW'(mix_s6) << F) + CW'(nrm_s6 >> 1);

	always_ff @(posedge clk) begin
		if (en7) begin
			raw_s7 <= raw_s6;
			neg_s7 <= neg_s6;
			byp_s7 <= byp_s6;
			d_s7 <= dnext;
			nrm_s7 <= nrm_s6;
			ovf_s7 <= dnext >= (CW'(nrm_s6) << QB);
		end
	end

	logic [QB-1:0] q_div;
	logic [SW-1:0] side_div;

	tws_div #(
		.DW(CW),
		.NW(TW),
		.QB(QB),
		.SW(SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s7),
		.in_ready (div_in_ready),
		.in_d     (d_s7),
		.in_norm  (nrm_s7),
		.in_side  ({ovf_s7, byp_s7, neg_s7, raw_s7}),
		.out_valid(div_out_valid),
		.out_ready(div_out_ready),
		.out_q    (q_div),
		.out_side (side_div)
	);

	// output register with sign and clamp
	logic          out_v_q;
	logic [SB-1:0] out_q;
	logic [SB-1:0] res;
	logic          r_ovf, r_byp, r_neg;
	logic [SB-1:0] r_raw;

	assign {r_ovf, r_byp, r_neg, r_raw} = side_div;
	assign div_out_ready = !out_v_q || out_ch.ready;

	always_comb begin
		priority if (r_byp) begin
			res = r_raw;
		end else if (r_neg) begin
			res = (r_ovf || q_div > QB'(SMIN)) ? SMIN : SB'(-q_div);
		end else begin
			res = (r_ovf || q_div > QB'(SMAX)) ? SMAX : q_div[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (div_out_ready) begin
			out_v_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out_ready) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.sample_out = out_q;

`ifndef SYNTHESIS
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (out_ch.valid && !out_ch.ready))
		else $error("input stalled while output not stalled");

	a_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_q <= LEVEL_MAX) && (char_q <= LEVEL_MAX))
		else $error("level register above limit");

	a_norm_floor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (nrm_s6 >= THR))
		else $error("divisor below floor");
`endif

endmodule
